@@ hdl/dark_line_centroid_pid_assert.svh @@
// Assertion macros shared by the block's modules.
// Each macro takes a label, the clock, the reset, an antecedent and a consequent.
`ifndef DARK_LINE_CENTROID_PID_ASSERT_SVH
`define DARK_LINE_CENTROID_PID_ASSERT_SVH

`ifndef SYNTHESIS

`define DLC_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

`define DLC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`else

`define DLC_ASSERT_SAME(lbl, clk, rst, ante, cons)

`define DLC_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

@@ hdl/dlc_pkg.sv @@
`default_nettype none

package dlc_pkg;

  // Image geometry.
  localparam int BAND_WIDTH   = 32;
  localparam int FRAME_HEIGHT = 240;
  localparam int NBANDS       = 10;
  localparam int LINE_W       = NBANDS * BAND_WIDTH;

  // Field widths.
  localparam int PIX_W    = 8;
  localparam int COLUMN_W = 9;
  localparam int POS_W    = (COLUMN_W > $clog2(LINE_W + 1)) ? COLUMN_W : $clog2(LINE_W + 1);
  localparam int IDX_W    = $clog2(NBANDS);
  localparam int COUNT_W  = 13;
  localparam int TOTAL_W  = 17;
  localparam int GAIN_W   = 8;
  localparam int NOLINE_W = 16;
  localparam int DRIVE_W  = 24;
  localparam int ERR_W    = 13;
  localparam int ACC_W    = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // A band count stops at whichever is smaller: a full band or the counter range.
  localparam int BAND_FULL  = BAND_WIDTH * FRAME_HEIGHT;
  localparam int BAND_LIMIT = (BAND_FULL < (2 ** COUNT_W - 1)) ? BAND_FULL : (2 ** COUNT_W - 1);

  // Weighted sum and division.
  localparam int WEIGHT_W   = 5;
  localparam int NUM_W      = 21;
  localparam int FRAC_SHIFT = 7;
  localparam int DIVIDEND_W = NUM_W - 1 + FRAC_SHIFT;
  localparam int DIVISOR_W  = TOTAL_W + 1;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

  // Shared multiplier and PID sum.
  localparam int MUL_B_W = ACC_W + 1;
  localparam int PROD_W  = GAIN_W + 1 + MUL_B_W;
  localparam int SHIFT_Q = 8;
  localparam int SCALED_W = PROD_W - SHIFT_Q;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_DARK_LIMIT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DARK      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NO_LINE_DRIVE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D        = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_CHECK,
    S_DIVIDE,
    S_UPDATE,
    S_MUL,
    S_FINISH
  } seq_state_t;

  typedef struct packed {
    logic             count_en;
    logic             sweep_en;
    logic [IDX_W-1:0] sweep_idx;
  } bands_ctl_t;

  // Band k of the flipped image weighs (2k - 9) halves.
  function automatic logic signed [WEIGHT_W-1:0] band_weight(input logic [IDX_W-1:0] idx);
    logic signed [WEIGHT_W-1:0] w;
    w = $signed(WEIGHT_W'({idx, 1'b0})) - WEIGHT_W'(NBANDS - 1);
    return w;
  endfunction

endpackage

`default_nettype wire

@@ hdl/dlc_bands.sv @@
`default_nettype none

module dlc_bands (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic [dlc_pkg::PIX_W-1:0]         blue,
  input  wire logic [dlc_pkg::PIX_W-1:0]         green_level,
  input  wire logic [dlc_pkg::PIX_W-1:0]         red,
  input  wire logic [dlc_pkg::COLUMN_W-1:0]      column,
  input  wire logic [dlc_pkg::PIX_W-1:0]         dark_limit,
  input  wire dlc_pkg::bands_ctl_t               ctl,
  output logic      [dlc_pkg::COUNT_W-1:0]       sweep_count
);

  logic [dlc_pkg::COUNT_W-1:0] counts [dlc_pkg::NBANDS];
  logic [dlc_pkg::POS_W-1:0]   pos;
  logic [dlc_pkg::POS_W-1:0]   flip;
  logic [dlc_pkg::POS_W-1:0]   band_full;
  logic [dlc_pkg::IDX_W-1:0]   band;
  logic                        is_dark;
  logic                        in_line;
  logic                        hit;

  // Dark means the largest component is at or below the limit.
  assign is_dark = (blue <= dark_limit) && (green_level <= dark_limit) && (red <= dark_limit);
  assign pos       = dlc_pkg::POS_W'(column);
  assign in_line   = pos < dlc_pkg::POS_W'(dlc_pkg::LINE_W);
  // The image is rotated by half a turn, so columns count from the right.
  assign flip      = dlc_pkg::POS_W'(dlc_pkg::LINE_W - 1) - pos;
  assign band_full = dlc_pkg::POS_W'(flip / dlc_pkg::BAND_WIDTH);
  assign band      = band_full[dlc_pkg::IDX_W-1:0];
  assign hit       = ctl.count_en && is_dark && in_line &&
                     (counts[band] < dlc_pkg::COUNT_W'(dlc_pkg::BAND_LIMIT));

  assign sweep_count = counts[ctl.sweep_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < dlc_pkg::NBANDS; i++) begin
        counts[i] <= '0;
      end
    end else begin
      if (hit) begin
        counts[band] <= counts[band] + 1'b1;
      end
      // The frame-end sweep reads each band once and clears it behind itself.
      if (ctl.sweep_en) begin
        counts[ctl.sweep_idx] <= '0;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/dlc_div.sv @@
`default_nettype none

`include "dark_line_centroid_pid_assert.svh"

module dlc_div (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  input  wire logic [dlc_pkg::DIVIDEND_W-1:0]     dividend,
  input  wire logic [dlc_pkg::DIVISOR_W-1:0]      divisor,
  output logic      [dlc_pkg::DIVIDEND_W-1:0]     quotient,
  output logic                                    done
);

  logic                              busy;
  logic [dlc_pkg::DIV_CNT_W-1:0]     cnt;
  logic [dlc_pkg::DIVISOR_W-1:0]     rem;
  logic [dlc_pkg::DIVIDEND_W-1:0]    quo;
  logic [dlc_pkg::DIVISOR_W:0]       shifted;
  logic [dlc_pkg::DIVISOR_W:0]       diff;
  logic                              fits;

  // Restoring division, one quotient bit per cycle.
  assign shifted  = {rem, quo[dlc_pkg::DIVIDEND_W-1]};
  assign diff     = shifted - {1'b0, divisor};
  assign fits     = shifted >= {1'b0, divisor};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == dlc_pkg::DIV_CNT_W'(dlc_pkg::DIVIDEND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      if (fits) begin
        rem <= diff[dlc_pkg::DIVISOR_W-1:0];
      end else begin
        rem <= shifted[dlc_pkg::DIVISOR_W-1:0];
      end
      quo <= {quo[dlc_pkg::DIVIDEND_W-2:0], fits};
    end
  end

  `DLC_ASSERT_NEXT(a_start_busy, clk, rst, start, busy)
  `DLC_ASSERT_SAME(a_done_idle, clk, rst, done, !busy)
  `DLC_ASSERT_NEXT(a_last_done, clk, rst,
                   busy && !start && (cnt == dlc_pkg::DIV_CNT_W'(dlc_pkg::DIVIDEND_W - 1)), done)

endmodule

`default_nettype wire

@@ hdl/dark_line_centroid_pid.sv @@
// Plain pixels: accepted one per cycle, counted in the cycle they are taken.
// Frame-end pixel: the result follows the band sweep, the restoring divider and
// the shared 9x25 multiplier (both skipped with no line). in_ready is low from a
// frame-end word until its result is loaded into the output register. Synchronous
// reset clears band counts and PID state and loads the config defaults.
`default_nettype none

`include "dark_line_centroid_pid_assert.svh"

module dark_line_centroid_pid (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [dlc_pkg::PIX_W-1:0]           blue,
  input  wire logic [dlc_pkg::PIX_W-1:0]           green_level,
  input  wire logic [dlc_pkg::PIX_W-1:0]           red,
  input  wire logic [dlc_pkg::COLUMN_W-1:0]        column,
  input  wire logic                                frame_end,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [dlc_pkg::DRIVE_W-1:0]       drive,
  output logic                                     line_found,
  output logic      [dlc_pkg::TOTAL_W-1:0]         dark_total,
  input  wire logic                                cfg_we,
  input  wire logic [dlc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [dlc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // Configuration.
  logic [dlc_pkg::PIX_W-1:0]            dark_limit;
  logic [dlc_pkg::TOTAL_W-1:0]          min_dark_pixels;
  logic signed [dlc_pkg::NOLINE_W-1:0]  no_line_drive;
  logic [dlc_pkg::GAIN_W-1:0]           gain_p;
  logic [dlc_pkg::GAIN_W-1:0]           gain_i;
  logic [dlc_pkg::GAIN_W-1:0]           gain_d;

  // Sequencer.
  dlc_pkg::seq_state_t                  state;
  dlc_pkg::seq_state_t                  state_next;
  logic [dlc_pkg::IDX_W-1:0]            idx;
  logic [1:0]                           mul_step;
  dlc_pkg::bands_ctl_t                  bands_ctl;
  logic                                 in_accept;
  logic                                 div_start;
  logic                                 div_done;
  logic                                 out_load;
  logic                                 no_line;

  // Datapath.
  logic [dlc_pkg::COUNT_W-1:0]          sweep_count;
  logic [dlc_pkg::TOTAL_W-1:0]          total;
  logic signed [dlc_pkg::NUM_W-1:0]     num;
  logic signed [dlc_pkg::COUNT_W+dlc_pkg::WEIGHT_W:0] wprod;
  logic [dlc_pkg::NUM_W-2:0]            num_mag;
  logic [dlc_pkg::DIVIDEND_W-1:0]       dividend;
  logic [dlc_pkg::DIVISOR_W-1:0]        divisor;
  logic [dlc_pkg::DIVIDEND_W-1:0]       quotient;
  logic signed [dlc_pkg::ERR_W-1:0]     e_val;
  logic signed [dlc_pkg::ERR_W-1:0]     error_now;
  logic signed [dlc_pkg::ERR_W-1:0]     error_before;
  logic signed [dlc_pkg::ACC_W-1:0]     error_accum;
  logic signed [dlc_pkg::ACC_W:0]       accum_sum;
  logic signed [dlc_pkg::ACC_W-1:0]     accum_sat;
  logic [dlc_pkg::GAIN_W-1:0]           mul_a;
  logic signed [dlc_pkg::MUL_B_W-1:0]   mul_b;
  logic signed [dlc_pkg::PROD_W-1:0]    prod;
  logic signed [dlc_pkg::PROD_W-1:0]    pid_sum;
  logic signed [dlc_pkg::PROD_W-1:0]    pid_adj;
  logic signed [dlc_pkg::SCALED_W-1:0]  scaled;
  logic signed [dlc_pkg::DRIVE_W-1:0]   drive_sat;
  logic                                 found;

  assign in_accept = in_valid && in_ready;

  dlc_bands u_bands (
    .clk         (clk),
    .rst         (rst),
    .blue        (blue),
    .green_level (green_level),
    .red         (red),
    .column      (column),
    .dark_limit  (dark_limit),
    .ctl         (bands_ctl),
    .sweep_count (sweep_count)
  );

  assign num_mag  = num[dlc_pkg::NUM_W-1] ? (dlc_pkg::NUM_W-1)'(-num)
                                          : num[dlc_pkg::NUM_W-2:0];
  assign dividend = {num_mag, dlc_pkg::FRAC_SHIFT'(0)};
  assign divisor  = {1'b0, total} + 1'b1;

  dlc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .quotient (quotient),
    .done     (div_done)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      dlc_pkg::S_IDLE: begin
        if (in_accept && frame_end) begin
          state_next = dlc_pkg::S_SUM;
        end
      end
      dlc_pkg::S_SUM: begin
        if (idx == dlc_pkg::IDX_W'(dlc_pkg::NBANDS - 1)) begin
          state_next = dlc_pkg::S_CHECK;
        end
      end
      dlc_pkg::S_CHECK: begin
        if (no_line) begin
          state_next = dlc_pkg::S_FINISH;
        end else begin
          state_next = dlc_pkg::S_DIVIDE;
        end
      end
      dlc_pkg::S_DIVIDE: begin
        if (div_done) begin
          state_next = dlc_pkg::S_UPDATE;
        end
      end
      dlc_pkg::S_UPDATE: begin
        state_next = dlc_pkg::S_MUL;
      end
      dlc_pkg::S_MUL: begin
        if (mul_step == 2'd3) begin
          state_next = dlc_pkg::S_FINISH;
        end
      end
      dlc_pkg::S_FINISH: begin
        if (out_load) begin
          state_next = dlc_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = dlc_pkg::S_IDLE;
      end
    endcase
  end

  // Control outputs.
  always_comb begin
    in_ready            = 1'b0;
    div_start           = 1'b0;
    out_load            = 1'b0;
    bands_ctl.count_en  = 1'b0;
    bands_ctl.sweep_en  = 1'b0;
    bands_ctl.sweep_idx = idx;
    unique case (state)
      dlc_pkg::S_IDLE: begin
        in_ready           = 1'b1;
        bands_ctl.count_en = in_valid;
      end
      dlc_pkg::S_SUM: begin
        bands_ctl.sweep_en = 1'b1;
      end
      dlc_pkg::S_CHECK: begin
        div_start = !no_line;
      end
      dlc_pkg::S_FINISH: begin
        out_load = !out_valid || out_ready;
      end
      default: begin
      end
    endcase
  end

  assign no_line = total < min_dark_pixels;
  assign wprod   = $signed({1'b0, sweep_count}) * dlc_pkg::band_weight(idx);

  // Signed error from the magnitude quotient, which never exceeds 1152.
  assign e_val = num[dlc_pkg::NUM_W-1] ? -$signed({1'b0, quotient[dlc_pkg::ERR_W-2:0]})
                                       :  $signed({1'b0, quotient[dlc_pkg::ERR_W-2:0]});

  assign accum_sum = (dlc_pkg::ACC_W + 1)'(error_accum) + (dlc_pkg::ACC_W + 1)'(e_val);
  always_comb begin
    if (accum_sum[dlc_pkg::ACC_W] != accum_sum[dlc_pkg::ACC_W-1]) begin
      accum_sat = accum_sum[dlc_pkg::ACC_W] ? {1'b1, {(dlc_pkg::ACC_W-1){1'b0}}}
                                            : {1'b0, {(dlc_pkg::ACC_W-1){1'b1}}};
    end else begin
      accum_sat = accum_sum[dlc_pkg::ACC_W-1:0];
    end
  end

  // Operand select for the shared multiplier: P term, I term, then D term.
  always_comb begin
    unique case (mul_step)
      2'd0: begin
        mul_a = gain_p;
        mul_b = dlc_pkg::MUL_B_W'(error_now);
      end
      2'd1: begin
        mul_a = gain_i;
        mul_b = dlc_pkg::MUL_B_W'(error_accum);
      end
      2'd2: begin
        mul_a = gain_d;
        mul_b = dlc_pkg::MUL_B_W'(error_now) - dlc_pkg::MUL_B_W'(error_before);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Divide by 256 rounding toward zero, then saturate to the drive range.
  assign pid_adj = pid_sum[dlc_pkg::PROD_W-1]
                   ? pid_sum + dlc_pkg::PROD_W'((1 << dlc_pkg::SHIFT_Q) - 1) : pid_sum;
  assign scaled  = pid_adj[dlc_pkg::PROD_W-1:dlc_pkg::SHIFT_Q];
  always_comb begin
    if (scaled > dlc_pkg::SCALED_W'((1 << (dlc_pkg::DRIVE_W - 1)) - 1)) begin
      drive_sat = {1'b0, {(dlc_pkg::DRIVE_W-1){1'b1}}};
    end else if (scaled < -$signed(dlc_pkg::SCALED_W'(1 << (dlc_pkg::DRIVE_W - 1)))) begin
      drive_sat = {1'b1, {(dlc_pkg::DRIVE_W-1){1'b0}}};
    end else begin
      drive_sat = scaled[dlc_pkg::DRIVE_W-1:0];
    end
  end

  // Control and architectural state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= dlc_pkg::S_IDLE;
      idx             <= '0;
      mul_step        <= '0;
      out_valid       <= 1'b0;
      error_now       <= '0;
      error_before    <= '0;
      error_accum     <= '0;
      dark_limit      <= dlc_pkg::PIX_W'(51);
      min_dark_pixels <= dlc_pkg::TOTAL_W'(100);
      no_line_drive   <= dlc_pkg::NOLINE_W'(99);
      gain_p          <= dlc_pkg::GAIN_W'(15);
      gain_i          <= '0;
      gain_d          <= '0;
    end else begin
      state <= state_next;
      if (state == dlc_pkg::S_SUM) begin
        idx <= idx + 1'b1;
      end else begin
        idx <= '0;
      end
      if (state == dlc_pkg::S_MUL) begin
        mul_step <= mul_step + 1'b1;
      end else begin
        mul_step <= '0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == dlc_pkg::S_UPDATE) begin
        error_before <= error_now;
        error_now    <= e_val;
        error_accum  <= accum_sat;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          dlc_pkg::REG_DARK_LIMIT:    dark_limit      <= cfg_data[dlc_pkg::PIX_W-1:0];
          dlc_pkg::REG_MIN_DARK:      min_dark_pixels <= cfg_data[dlc_pkg::TOTAL_W-1:0];
          dlc_pkg::REG_NO_LINE_DRIVE: no_line_drive   <= cfg_data[dlc_pkg::NOLINE_W-1:0];
          dlc_pkg::REG_GAIN_P:        gain_p          <= cfg_data[dlc_pkg::GAIN_W-1:0];
          dlc_pkg::REG_GAIN_I:        gain_i          <= cfg_data[dlc_pkg::GAIN_W-1:0];
          dlc_pkg::REG_GAIN_D:        gain_d          <= cfg_data[dlc_pkg::GAIN_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (state == dlc_pkg::S_IDLE) begin
      total <= '0;
      num   <= '0;
    end else if (state == dlc_pkg::S_SUM) begin
      total <= total + dlc_pkg::TOTAL_W'(sweep_count);
      num   <= num + dlc_pkg::NUM_W'(wprod);
    end
    // The product is registered and added in the next multiply step.
    prod <= $signed({1'b0, mul_a}) * mul_b;
    if (state == dlc_pkg::S_UPDATE) begin
      pid_sum <= '0;
    end else if (state == dlc_pkg::S_MUL && mul_step != 2'd0) begin
      pid_sum <= pid_sum + prod;
    end
    if (state == dlc_pkg::S_CHECK) begin
      found <= !no_line;
    end
    if (out_load) begin
      dark_total <= total;
      line_found <= found;
      if (found) begin
        drive <= drive_sat;
      end else begin
        drive <= dlc_pkg::DRIVE_W'(no_line_drive);
      end
    end
  end

  `DLC_ASSERT_SAME(a_result_from_finish, clk, rst,
                   $rose(out_valid), $past(state == dlc_pkg::S_FINISH))
  `DLC_ASSERT_SAME(a_found_enough, clk, rst,
                   out_valid && line_found, dark_total >= min_dark_pixels)
  `DLC_ASSERT_NEXT(a_div_to_update, clk, rst,
                   (state == dlc_pkg::S_DIVIDE) && div_done, state == dlc_pkg::S_UPDATE)

endmodule

`default_nettype wire

@@ bench/dlc_checker.sv @@
module dlc_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [dlc_pkg::PIX_W-1:0]          blue,
  input  logic [dlc_pkg::PIX_W-1:0]          green_level,
  input  logic [dlc_pkg::PIX_W-1:0]          red,
  input  logic [dlc_pkg::COLUMN_W-1:0]       column,
  input  logic                               frame_end,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic signed [dlc_pkg::DRIVE_W-1:0] drive,
  input  logic                               line_found,
  input  logic [dlc_pkg::TOTAL_W-1:0]        dark_total,
  input  logic                               cfg_we,
  input  logic [dlc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dlc_pkg::CFG_DATA_W-1:0]     cfg_data,
  output int                                 mismatch_count,
  output int                                 awaited_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint RAIL_HI = 8388607;
  localparam longint RAIL_LO = -8388608;
  localparam int unsigned COUNT_MAX = (1 << dlc_pkg::COUNT_W) - 1;
  localparam int unsigned BAND_CAP =
    (dlc_pkg::BAND_WIDTH * dlc_pkg::FRAME_HEIGHT < COUNT_MAX)
      ? dlc_pkg::BAND_WIDTH * dlc_pkg::FRAME_HEIGHT : COUNT_MAX;
  // Band weights are in halves, so the Q4.8 error carries a factor of 256 / 2.
  localparam longint HALF_SCALE = 128;
  localparam longint Q_SCALE = 256;
  localparam int PRINT_LIMIT = 100;

  typedef struct packed {
    logic signed [dlc_pkg::DRIVE_W-1:0] drive;
    logic                               line_found;
    logic [dlc_pkg::TOTAL_W-1:0]        dark_total;
  } steer_t;

  steer_t awaited_steer[$];
  int unsigned band_tally[dlc_pkg::NBANDS];
  logic [dlc_pkg::PIX_W-1:0] dark_limit_now;
  logic [dlc_pkg::TOTAL_W-1:0] min_pixels_now;
  logic signed [dlc_pkg::NOLINE_W-1:0] no_line_code;
  longint kp, ki, kd;
  longint err_now, err_prev, err_sum;
  int mismatches = 0;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) $display("%0t ns: mismatch: %s", $time, what);
  endtask

  function automatic longint to_rail(input longint v);
    if (v > RAIL_HI) return RAIL_HI;
    if (v < RAIL_LO) return RAIL_LO;
    return v;
  endfunction

  always @(posedge clk) begin : steering_model
    steer_t want;
    logic [dlc_pkg::PIX_W-1:0] brightest;
    int band;
    int k;
    int unsigned total;
    longint weighted;
    longint sum;

    if (rst) begin
      dark_limit_now = 8'd51;
      min_pixels_now = 17'd100;
      no_line_code = 16'sd99;
      kp = 15;
      ki = 0;
      kd = 0;
      err_now = 0;
      err_prev = 0;
      err_sum = 0;
      for (k = 0; k < dlc_pkg::NBANDS; k++) band_tally[k] = 0;
      awaited_steer.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_steer.size() == 0) begin
          report_mismatch($sformatf("steering word with none awaited, drive %0d", drive));
        end else begin
          want = awaited_steer.pop_front();
          if (drive !== want.drive)
            report_mismatch($sformatf("drive %0d, wanted %0d", drive, $signed(want.drive)));
          if (line_found !== want.line_found)
            report_mismatch($sformatf("line_found %b, wanted %b", line_found, want.line_found));
          if (dark_total !== want.dark_total)
            report_mismatch($sformatf("dark_total %0d, wanted %0d", dark_total,
                                      want.dark_total));
        end
      end

      if (cfg_we) begin
        case (cfg_index)
          dlc_pkg::REG_DARK_LIMIT:    dark_limit_now = cfg_data[dlc_pkg::PIX_W-1:0];
          dlc_pkg::REG_MIN_DARK:      min_pixels_now = cfg_data[dlc_pkg::TOTAL_W-1:0];
          dlc_pkg::REG_NO_LINE_DRIVE: no_line_code = cfg_data[dlc_pkg::NOLINE_W-1:0];
          dlc_pkg::REG_GAIN_P:        kp = cfg_data[dlc_pkg::GAIN_W-1:0];
          dlc_pkg::REG_GAIN_I:        ki = cfg_data[dlc_pkg::GAIN_W-1:0];
          dlc_pkg::REG_GAIN_D:        kd = cfg_data[dlc_pkg::GAIN_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && in_ready) begin
        brightest = (blue > green_level) ? blue : green_level;
        if (red > brightest) brightest = red;
        // The image is flipped, so column 0 lands in the rightmost band.
        if (brightest <= dark_limit_now && column < dlc_pkg::LINE_W) begin
          band = (dlc_pkg::LINE_W - 1 - int'(column)) / dlc_pkg::BAND_WIDTH;
          if (band_tally[band] < BAND_CAP) band_tally[band]++;
        end

        if (frame_end) begin
          total = 0;
          weighted = 0;
          for (k = 0; k < dlc_pkg::NBANDS; k++) begin
            total += band_tally[k];
            weighted += longint'(band_tally[k]) * (2 * k - (dlc_pkg::NBANDS - 1));
          end
          want.dark_total = dlc_pkg::TOTAL_W'(total);
          if (total < min_pixels_now) begin
            want.drive = {{(dlc_pkg::DRIVE_W - dlc_pkg::NOLINE_W)
                           {no_line_code[dlc_pkg::NOLINE_W-1]}}, no_line_code};
            want.line_found = 1'b0;
          end else begin
            err_prev = err_now;
            err_now = (weighted * HALF_SCALE) / (longint'(total) + 1);
            err_sum = to_rail(err_sum + err_now);
            sum = kp * err_now + ki * err_sum + kd * (err_now - err_prev);
            want.drive = dlc_pkg::DRIVE_W'(to_rail(sum / Q_SCALE));
            want.line_found = 1'b1;
          end
          awaited_steer.push_back(want);
          for (k = 0; k < dlc_pkg::NBANDS; k++) band_tally[k] = 0;
        end
      end
    end

    awaited_count <= awaited_steer.size();
    mismatch_count <= mismatches;
  end

endmodule

@@ bench/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Indexes past the register list; writes there must change nothing.
  localparam logic [dlc_pkg::CFG_IDX_W-1:0] REG_SPARE_LOW = dlc_pkg::REG_GAIN_D + 1'b1;
  localparam logic [dlc_pkg::CFG_IDX_W-1:0] REG_SPARE_TOP = {dlc_pkg::CFG_IDX_W{1'b1}};
  localparam int COLUMN_MAX = (1 << dlc_pkg::COLUMN_W) - 1;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [dlc_pkg::PIX_W-1:0] blue;
  logic [dlc_pkg::PIX_W-1:0] green_level;
  logic [dlc_pkg::PIX_W-1:0] red;
  logic [dlc_pkg::COLUMN_W-1:0] column;
  logic frame_end;
  logic out_valid;
  logic out_ready;
  logic signed [dlc_pkg::DRIVE_W-1:0] drive;
  logic line_found;
  logic [dlc_pkg::TOTAL_W-1:0] dark_total;
  logic cfg_we;
  logic [dlc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [dlc_pkg::CFG_DATA_W-1:0] cfg_data;
  int mismatch_count;
  int awaited_count;

  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;
  int dark_lim = 51;

  always #10 clk = ~clk;

  dark_line_centroid_pid uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .blue(blue), .green_level(green_level), .red(red), .column(column),
    .frame_end(frame_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .drive(drive), .line_found(line_found), .dark_total(dark_total),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  dlc_checker watch (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .blue(blue), .green_level(green_level), .red(red), .column(column),
    .frame_end(frame_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .drive(drive), .line_found(line_found), .dark_total(dark_total),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatch_count(mismatch_count), .awaited_count(awaited_count)
  );

  task automatic send_pixel(input logic [dlc_pkg::PIX_W-1:0] b,
                            input logic [dlc_pkg::PIX_W-1:0] g,
                            input logic [dlc_pkg::PIX_W-1:0] r, input int col, input bit last);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    blue <= b;
    green_level <= g;
    red <= r;
    column <= dlc_pkg::COLUMN_W'(col);
    frame_end <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Dark pixels cluster around a line position; the rest are random colors.
  task automatic send_random_pixel(input bit last, input int center);
    logic [dlc_pkg::PIX_W-1:0] shade[3];
    int col;
    bit dark;
    dark = $urandom_range(0, 1);
    foreach (shade[i])
      shade[i] = dark ? dlc_pkg::PIX_W'($urandom_range(0, dark_lim)) : dlc_pkg::PIX_W'($urandom);
    if ($urandom_range(0, 19) == 0) col = $urandom_range(dlc_pkg::LINE_W, COLUMN_MAX);
    else if (dark && $urandom_range(0, 4) != 0)
      col = (center + $urandom_range(0, 63)) % dlc_pkg::LINE_W;
    else col = $urandom_range(0, dlc_pkg::LINE_W - 1);
    send_pixel(shade[0], shade[1], shade[2], col, last);
  endtask

  task automatic write_reg(input logic [dlc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dlc_pkg::CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  // Bits above each register's width carry junk that the block must drop.
  task automatic apply_setting(input int dl, input int md, input int nl,
                               input int gp, input int gi, input int gd);
    write_reg(REG_SPARE_LOW, dlc_pkg::CFG_DATA_W'($urandom));
    write_reg(dlc_pkg::REG_DARK_LIMIT, {9'($urandom), 8'(dl)});
    write_reg(dlc_pkg::REG_MIN_DARK, 17'(md));
    write_reg(dlc_pkg::REG_NO_LINE_DRIVE, {1'($urandom), 16'(nl)});
    write_reg(dlc_pkg::REG_GAIN_P, {9'($urandom), 8'(gp)});
    write_reg(dlc_pkg::REG_GAIN_I, {9'($urandom), 8'(gi)});
    write_reg(dlc_pkg::REG_GAIN_D, {9'($urandom), 8'(gd)});
    write_reg(REG_SPARE_TOP, dlc_pkg::CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    dark_lim = dl;
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (awaited_count != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic int pick_gain();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  initial begin : out_side
    int hold;
    hold = 0;
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(0, 13);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int phase, sent, len, center, i;
    rst <= 1'b1;
    in_valid <= 1'b0;
    blue <= '0;
    green_level <= '0;
    red <= '0;
    column <= '0;
    frame_end <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: one bright channel each, the dark limit on both sides,
    // columns past the image, and too few dark pixels for a line.
    send_pixel(8'd255, 8'd0, 8'd0, 0, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd0, 1, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd255, 2, 1'b0);
    send_pixel(8'd51, 8'd51, 8'd51, dlc_pkg::LINE_W - 1, 1'b0);
    send_pixel(8'd52, 8'd0, 8'd0, dlc_pkg::LINE_W - 2, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd0, dlc_pkg::LINE_W, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd0, COLUMN_MAX, 1'b0);
    send_pixel(8'd51, 8'd0, 8'd51, dlc_pkg::LINE_W / 2, 1'b1);
    in_valid <= 1'b0;

    // Every pixel dark: one at an edge of every band, then an empty frame.
    wait_idle();
    apply_setting(255, 0, -32768, 255, 255, 255);
    for (i = 0; i < dlc_pkg::NBANDS; i++)
      send_pixel(dlc_pkg::PIX_W'($urandom), dlc_pkg::PIX_W'($urandom),
                 dlc_pkg::PIX_W'($urandom),
                 i * dlc_pkg::BAND_WIDTH + ((i % 2) ? dlc_pkg::BAND_WIDTH - 1 : 0), 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 100, 1'b1);
    send_pixel(8'd0, 8'd0, 8'd0, dlc_pkg::LINE_W + 80, 1'b1);
    in_valid <= 1'b0;

    // Dark limit zero; a total equal to the minimum still finds the line.
    wait_idle();
    apply_setting(0, 2, 32767, 0, 0, 0);
    send_pixel(8'd1, 8'd0, 8'd0, 5, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd0, 5, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd0, 300, 1'b1);
    send_pixel(8'd0, 8'd0, 8'd0, 10, 1'b1);
    in_valid <= 1'b0;

    // The last phase runs with no idling on either side.
    for (phase = 0; phase < 10; phase++) begin
      wait_idle();
      case (phase)
        0: apply_setting(255, 76800, 32767, 255, 255, 255);
        1: apply_setting(0, 0, -32768, 0, 0, 0);
        default: apply_setting($urandom_range(0, 255), $urandom_range(0, 25),
                               $urandom_range(0, 65535), pick_gain(), pick_gain(), pick_gain());
      endcase
      gaps_on = (phase != 2) && (phase != 9) && ($urandom_range(0, 3) != 0);
      stalls_on = (phase != 2) && (phase != 9) && ($urandom_range(0, 3) != 0);
      sent = 0;
      while (sent < 95) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(31, 150) : $urandom_range(1, 30);
        center = $urandom_range(0, dlc_pkg::LINE_W - 1);
        for (i = 0; i < len; i++) send_random_pixel(i == len - 1, center);
        sent += len;
      end
      in_valid <= 1'b0;
    end

    wait_idle();
    if (mismatch_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
